[hdl/vteq_pkg.sv]
// Shared types and codes for the virtual time event queue.
`timescale 1ns / 1ps
`default_nettype none

package vteq_pkg;

  localparam int unsigned TOKEN_W = 6;
  localparam int unsigned TIME_W  = 31;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned ARG_W   = 32;

  typedef enum logic [1:0] {
    REQ_SCHED  = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_POP    = 2'd2
  } vteq_req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } vteq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FIN
  } vteq_state_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [TIME_W-1:0]       event_time;
    logic [TAG_W-1:0]        handler_id;
    logic signed [ARG_W-1:0] event_arg;
    logic [TOKEN_W-1:0]      token;
  } vteq_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [TOKEN_W-1:0]      slot_token;
    logic [TIME_W-1:0]       fire_time;
    logic [TAG_W-1:0]        fire_handler;
    logic signed [ARG_W-1:0] fire_arg;
    logic [TIME_W-1:0]       current_time;
  } vteq_out_t;

endpackage

`default_nettype wire

[hdl/virtual_time_event_queue.sv]
// Virtual time event queue: slot table, sequential earliest-event scan, result register.
//
// Usage: one request word enters on in_valid/in_ready and exactly one result word
// leaves on out_valid/out_ready. Schedule stores the event in the next unused slot
// and returns that slot as a token; slots are never reused, so the queue reports
// full after SLOTS schedules. Cancel clears a handed-out token. Pop returns the
// alive event with the lowest time (lowest slot on ties) and moves the virtual
// clock to its time, or reports empty.
// Schedule and cancel register their result in the cycle after acceptance.
// A pop walks the used slots through one comparator, one slot per cycle, out of
// the registered read port of the slot memories, then passes S_LAST and S_FIN
// before its result is registered; with no slot in use a pop is answered like a cancel.
// Throughput: one request at a time; in_ready is high only while no pop is in
// progress and the result register is free or being emptied.
// Reset: clears the slot fill count, the virtual clock and the handshake state;
// slot contents need no clearing because only slots below the fill count are read.
// Stall: a result waits in the output register until out_ready; a finished pop
// holds its result inside until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module virtual_time_event_queue
  import vteq_pkg::*;
#(
  parameter int unsigned SLOTS = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire vteq_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output vteq_out_t      out_data
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned UW = $clog2(SLOTS + 1);
  localparam int unsigned XW = (UW > TOKEN_W) ? UW : TOKEN_W;

  logic [TIME_W-1:0] slot_time_mem    [SLOTS];
  logic [TAG_W-1:0]  slot_handler_mem [SLOTS];
  logic [ARG_W-1:0]  slot_arg_mem     [SLOTS];
  logic              slot_alive_mem   [SLOTS];

  vteq_state_t       state_r, state_nxt;
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [UW-1:0]     used_r, used_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              out_valid_r, out_valid_nxt;
  vteq_out_t         out_data_r, out_data_nxt;

  logic              chk_vld_r;
  logic [AW-1:0]     chk_idx_r;
  logic [TIME_W-1:0] rd_time_r;
  logic [TAG_W-1:0]  rd_handler_r;
  logic [ARG_W-1:0]  rd_arg_r;
  logic              rd_alive_r;

  logic              found_r;
  logic [AW-1:0]     best_idx_r;
  logic [TIME_W-1:0] best_time_r;
  logic [TAG_W-1:0]  best_handler_r;
  logic [ARG_W-1:0]  best_arg_r;
  logic              take_best;

  logic              out_free;
  logic              scan_issue;
  logic              data_we;
  logic              alive_we;
  logic [AW-1:0]     alive_wa;
  logic              alive_wd;
  logic [XW-1:0]     tok_x;
  logic [XW-1:0]     used_x;
  vteq_out_t         res;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign tok_x     = XW'(in_data.token);
  assign used_x    = XW'(used_r);
  assign take_best = chk_vld_r && rd_alive_r && (!found_r || (rd_time_r < best_time_r));

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    used_nxt      = used_r;
    now_nxt       = now_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    scan_issue    = 1'b0;
    data_we       = 1'b0;
    alive_we      = 1'b0;
    alive_wa      = '0;
    alive_wd      = 1'b0;
    res           = '0;
    res.current_time = now_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          unique case (in_data.req_type)
            REQ_SCHED: begin
              if (used_r == UW'(SLOTS)) begin
                res.status = STAT_FULL;
              end else begin
                data_we        = 1'b1;
                alive_we       = 1'b1;
                alive_wa       = AW'(used_r);
                alive_wd       = 1'b1;
                used_nxt       = used_r + UW'(1);
                res.slot_token = TOKEN_W'(used_r);
              end
            end
            REQ_CANCEL: begin
              if (tok_x < used_x) begin
                alive_we = 1'b1;
                alive_wa = tok_x[AW-1:0];
                alive_wd = 1'b0;
              end
            end
            REQ_POP: begin
              if (used_r == '0) begin
                res.status = STAT_EMPTY;
              end else begin
                state_nxt  = S_SCAN;
                rd_idx_nxt = '0;
              end
            end
            default: ;
          endcase
          if (state_nxt == S_IDLE) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = res;
          end
        end
      end
      S_SCAN: begin
        scan_issue = 1'b1;
        if (rd_idx_r == AW'(used_r - UW'(1))) begin
          state_nxt = S_LAST;
        end else begin
          rd_idx_nxt = rd_idx_r + AW'(1);
        end
      end
      S_LAST: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          if (found_r) begin
            res.fire_time    = best_time_r;
            res.fire_handler = best_handler_r;
            res.fire_arg     = best_arg_r;
            res.current_time = best_time_r;
            now_nxt          = best_time_r;
            alive_we         = 1'b1;
            alive_wa         = best_idx_r;
            alive_wd         = 1'b0;
          end else begin
            res.status = STAT_EMPTY;
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = res;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_idx_r    <= '0;
      used_r      <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      used_r      <= used_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= scan_issue;
      if (state_r == S_IDLE) begin
        found_r <= 1'b0;
      end else if (take_best) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    chk_idx_r  <= rd_idx_r;
    if (take_best) begin
      best_idx_r     <= chk_idx_r;
      best_time_r    <= rd_time_r;
      best_handler_r <= rd_handler_r;
      best_arg_r     <= rd_arg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      slot_time_mem[AW'(used_r)]    <= in_data.event_time;
      slot_handler_mem[AW'(used_r)] <= in_data.handler_id;
      slot_arg_mem[AW'(used_r)]     <= in_data.event_arg;
    end
    rd_time_r    <= slot_time_mem[rd_idx_r];
    rd_handler_r <= slot_handler_mem[rd_idx_r];
    rd_arg_r     <= slot_arg_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (alive_we) begin
      slot_alive_mem[alive_wa] <= alive_wd;
    end
    rd_alive_r <= slot_alive_mem[rd_idx_r];
  end

endmodule

`default_nettype wire
